// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: implication across reset");

`endif

// ===== rtl/core/pcgr_pkg.sv =====
package pcgr_pkg;

    localparam int DATA_W      = 32;
    localparam int SEED_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MUL_STEPS   = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [SEED_W-1:0] PCG_RESET = 64'h4D59_5DF4_D0F3_3173;
    localparam logic [SEED_W-1:0] PCG_MULT  = 64'h5851_F42D_4C95_7F2D;
    localparam logic [SEED_W-1:0] PCG_INC   = 64'h1405_7B7E_F767_814F;

    typedef enum logic [2:0] {
        OP_RAW    = 3'd0,
        OP_MOD    = 3'd1,
        OP_RANGE  = 3'd2,
        OP_EVEN   = 3'd3,
        OP_CHANCE = 3'd4,
        OP_RESEED = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DRAW,
        KIND_EVEN,
        KIND_CHANCE,
        KIND_RESEED
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               err;
        logic [DATA_W-1:0]  offset;
        logic [DATA_W-1:0]  modulus;
        logic [SEED_W-1:0]  seed;
    } t_cmd;

    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  dividend;
        logic [DATA_W-1:0]  divisor;
    } t_div_req;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ===== rtl/core/pcgr_front.sv =====
module pcgr_front
    import pcgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_opcode,
    input  logic [DATA_W-1:0]   i_first_arg,
    input  logic [DATA_W-1:0]   i_second_arg,
    input  logic [SEED_W-1:0]   i_seed_value,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_pop
);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;
    logic               push;
    t_cmd               cmd;

    always_comb begin
        cmd.kind    = KIND_NONE;
        cmd.err     = 1'b0;
        cmd.offset  = '0;
        cmd.modulus = '0;
        cmd.seed    = i_seed_value;
        case (t_opcode'(i_opcode))
            OP_RAW: begin
                cmd.kind = KIND_DRAW;
            end
            OP_MOD: begin
                cmd.kind    = KIND_DRAW;
                cmd.modulus = i_second_arg + 32'd1;
            end
            OP_RANGE: begin
                if (i_first_arg > i_second_arg) begin
                    cmd.err = 1'b1;
                end else begin
                    cmd.kind    = KIND_DRAW;
                    cmd.offset  = i_first_arg;
                    cmd.modulus = i_second_arg - i_first_arg + 32'd1;
                end
            end
            OP_EVEN: begin
                cmd.kind = KIND_EVEN;
            end
            OP_CHANCE: begin
                if (i_first_arg == '0) begin
                    cmd.err = 1'b1;
                end else begin
                    cmd.kind    = KIND_CHANCE;
                    cmd.modulus = i_first_arg;
                end
            end
            OP_RESEED: begin
                cmd.kind = KIND_RESEED;
            end
            default: begin
                cmd.kind = KIND_NONE;
            end
        endcase
    end

    assign o_in_stall  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ===== rtl/core/pcgr_divider.sv =====
module pcgr_divider
    import pcgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [DATA_W-1:0]   o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0]     r_rem;
    logic [DATA_W-1:0]     r_dvd;
    logic [DATA_W-1:0]     r_div;
    logic [DATA_W:0]       trial;
    logic [DATA_W:0]       diff;
    logic [DATA_W-1:0]     n_rem;

    assign trial = {r_rem, r_dvd[DATA_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign n_rem = (trial >= {1'b0, r_div}) ? diff[DATA_W-1:0] : trial[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/pcgr_back.sv =====
module pcgr_back
    import pcgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DATA_W-1:0]   o_value,
    output logic                o_error
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [SEED_W-1:0]  r_gen;
    logic [SEED_W-1:0]  r_acc;
    logic [1:0]         r_mcnt;
    t_cmd               r_cmd;
    logic [DATA_W-1:0]  r_draw;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_value;
    logic               r_out_error;

    logic [SEED_W-1:0]  xs;
    logic [DATA_W-1:0]  word;
    logic [2*DATA_W-1:0] rot;
    logic [DATA_W-1:0]  draw;
    logic [DATA_W-1:0]  op_a;
    logic [DATA_W-1:0]  op_b;
    logic [SEED_W-1:0]  prod;
    logic [SEED_W-1:0]  pp;
    logic               mul_last;
    logic               needs_div;
    logic               out_load;
    logic [DATA_W-1:0]  result;
    logic               div_done;
    logic [DATA_W-1:0]  div_rem;
    t_div_req           div_req;

    assign xs   = r_gen ^ (r_gen >> 18);
    assign word = xs[58:27];
    assign rot  = {word, word} >> r_gen[63:59];
    assign draw = rot[DATA_W-1:0];

    assign op_a = (r_mcnt == 2'd2) ? r_gen[63:32] : r_gen[31:0];
    assign op_b = (r_mcnt == 2'd1) ? PCG_MULT[63:32] : PCG_MULT[31:0];
    assign prod = SEED_W'(op_a) * SEED_W'(op_b);
    assign pp   = (r_mcnt == 2'd0) ? prod : {prod[DATA_W-1:0], {DATA_W{1'b0}}};

    assign mul_last  = (r_mcnt == 2'(MUL_STEPS - 1));
    assign needs_div = (r_cmd.kind inside {KIND_DRAW, KIND_CHANCE}) && (r_cmd.modulus != '0);

    always_comb begin
        result = '0;
        case (r_cmd.kind)
            KIND_DRAW: begin
                result = (r_cmd.modulus == '0) ? r_draw : r_cmd.offset + div_rem;
            end
            KIND_EVEN: begin
                result = {{(DATA_W-1){1'b0}}, ~r_draw[0]};
            end
            KIND_CHANCE: begin
                result = {{(DATA_W-1){1'b0}}, (div_rem == '0)};
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind inside {KIND_DRAW, KIND_EVEN, KIND_CHANCE}) begin
                        n_state = BK_MUL;
                    end else begin
                        n_state = BK_OUT;
                    end
                end
            end
            BK_MUL: begin
                if (mul_last) begin
                    n_state = needs_div ? BK_DIV : BK_OUT;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (out_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop            = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_draw;
        div_req.divisor  = r_cmd.modulus;
        case (r_state)
            BK_IDLE: begin
                o_pop = i_cmd_valid;
            end
            BK_MUL: begin
                div_req.start = mul_last && needs_div;
            end
            BK_OUT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    pcgr_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_gen       <= PCG_RESET;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_mcnt <= '0;
                if (i_cmd.kind == KIND_RESEED) begin
                    r_gen <= i_cmd.seed + PCG_INC;
                end
            end
            if (r_state == BK_MUL) begin
                r_mcnt <= r_mcnt + 1'b1;
                if (mul_last) begin
                    r_gen <= r_acc + pp;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_draw <= draw;
            r_acc  <= PCG_INC;
        end else if (r_state == BK_MUL) begin
            r_acc <= r_acc + pp;
        end
        if (out_load) begin
            r_out_value <= result;
            r_out_error <= r_cmd.err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_error     = r_out_error;

endmodule

// ===== rtl/core/pcg32_random_with_range.sv =====
// PCG32 XSH-RR generator with ranged draws, fair bits, one-in-N bits and reseeding.
// Each accepted item gives exactly one result, in order. A raw draw or a fair bit
// passes through the queue, then three 32x32 multiply-accumulate steps for the
// 64-bit state update, and then has its result loaded into the output register.
// A ranged draw or a one-in-N bit whose span is not the full 32-bit range also goes
// through the remainder unit, which retires one remainder bit per cycle and then
// flags completion. A reseed or an item with an error goes straight to the output
// register. Items are handled one at a time; a new item is taken only once the
// previous one has loaded its result. A two-entry queue takes new items while one is
// at work, and the output register holds a finished result while the receiver stalls.
module pcg32_random_with_range
    import pcgr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_opcode,
    input  logic [DATA_W-1:0]   i_first_arg,
    input  logic [DATA_W-1:0]   i_second_arg,
    input  logic [SEED_W-1:0]   i_seed_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DATA_W-1:0]   o_value,
    output logic                o_error
);

    logic  cmd_valid;
    t_cmd  cmd;
    logic  pop;

    pcgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_first_arg  (i_first_arg),
        .i_second_arg (i_second_arg),
        .i_seed_value (i_seed_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_pop        (pop)
    );

    pcgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_error     (o_error)
    );

endmodule

// ===== rtl/core/pcgr_checker.sv =====
`include "assert_macros.svh"

module pcgr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_in_stall,
    input  logic         o_out_valid,
    input  logic         i_out_stall,
    input  logic [31:0]  o_value,
    input  logic         o_error
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_out_valid && o_error, o_value == 32'd0)
    `ASSERT_NEXT_ALWAYS(a_rst_out, i_clk, !i_rst_n, !o_out_valid)
    `ASSERT_NEXT_ALWAYS(a_rst_in, i_clk, !i_rst_n, !o_in_stall)

endmodule

bind pcg32_random_with_range pcgr_checker u_pcgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_error     (o_error)
);

// ===== verif/pcg32_random_with_range_tb.sv =====
module pcg32_random_with_range_tb;
    import pcgr_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int PHASE_ITEMS   = 210;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [2:0]        op;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [SEED_W-1:0] seed;
    } t_draw_req;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              err;
    } t_draw_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_opcode = 3'd0;
    logic [DATA_W-1:0] i_first_arg = '0;
    logic [DATA_W-1:0] i_second_arg = '0;
    logic [SEED_W-1:0] i_seed_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DATA_W-1:0] o_value;
    logic              o_error;

    t_draw_req draw_requests[$];
    t_draw_res expected_draws[$];
    logic [SEED_W-1:0] pcg_state = PCG_RESET;
    logic in_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    bit hold_kick = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    pcg32_random_with_range uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_first_arg  (i_first_arg),
        .i_second_arg (i_second_arg),
        .i_seed_value (i_seed_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_error      (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] next_word();
        logic [SEED_W-1:0] prior;
        logic [SEED_W-1:0] mixed;
        logic [2*DATA_W-1:0] doubled;
        logic [DATA_W-1:0] word;
        prior = pcg_state;
        pcg_state = prior * PCG_MULT + PCG_INC;
        mixed = prior ^ (prior >> 18);
        word = mixed[58:27];
        doubled = {word, word} >> prior[63:59];
        return doubled[DATA_W-1:0];
    endfunction

    function automatic t_draw_res predict_draw(t_draw_req req);
        t_draw_res res;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] word;
        res.value = '0;
        res.err = 1'b0;
        case (req.op)
            OP_RAW: begin
                res.value = next_word();
            end
            OP_MOD: begin
                span = req.hi + 32'd1;
                word = next_word();
                res.value = (span == 0) ? word : word % span;
            end
            OP_RANGE: begin
                if (req.lo > req.hi) begin
                    res.err = 1'b1;
                end else begin
                    span = req.hi - req.lo + 32'd1;
                    word = next_word();
                    res.value = req.lo + ((span == 0) ? word : word % span);
                end
            end
            OP_EVEN: begin
                word = next_word();
                res.value = {31'd0, ~word[0]};
            end
            OP_CHANCE: begin
                if (req.lo == 0) begin
                    res.err = 1'b1;
                end else begin
                    word = next_word();
                    res.value = {31'd0, (word % req.lo) == 0};
                end
            end
            OP_RESEED: begin
                pcg_state = req.seed + PCG_INC;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void add_request(logic [2:0] op, logic [DATA_W-1:0] lo,
                                        logic [DATA_W-1:0] hi, logic [SEED_W-1:0] seed);
        t_draw_req req;
        req.op = op;
        req.lo = lo;
        req.hi = hi;
        req.seed = seed;
        draw_requests.insert(draw_requests.size(), req);
    endfunction

    function automatic logic [DATA_W-1:0] rand_arg();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_random_request();
        int pick;
        logic [2:0] op;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] swap;
        pick = $urandom_range(99);
        lo = $urandom;
        hi = $urandom;
        if (pick < 14) begin
            op = OP_RAW;
        end else if (pick < 32) begin
            op = OP_MOD;
            hi = rand_arg();
        end else if (pick < 58) begin
            op = OP_RANGE;
            lo = rand_arg();
            hi = rand_arg();
            if ($urandom_range(9) != 0 && lo > hi) begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
        end else if (pick < 68) begin
            op = OP_EVEN;
        end else if (pick < 88) begin
            op = OP_CHANCE;
            if ($urandom_range(19) == 0) begin
                lo = '0;
            end else if ($urandom_range(1) == 0) begin
                lo = $urandom_range(16, 1);
            end else begin
                lo = rand_arg();
            end
        end else if (pick < 97) begin
            op = OP_RESEED;
        end else begin
            op = ($urandom_range(1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
        end
        add_request(op, lo, hi, {$urandom, $urandom});
    endfunction

    task automatic wait_drained();
        while (draw_requests.size() != 0 || i_in_valid || expected_draws.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Driver: a payload stays put until its transfer completes.
    always @(negedge i_clk) begin
        t_draw_req req;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (draw_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = draw_requests.pop_front();
                i_opcode <= req.op;
                i_first_arg <= req.lo;
                i_second_arg <= req.hi;
                i_seed_value <= req.seed;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        t_draw_req req;
        t_draw_res want;
        logic in_fire;
        logic out_fire;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        in_taken <= in_fire;
        if (!i_rst_n) begin
            pcg_state = PCG_RESET;
        end
        if (in_fire) begin
            req.op = i_opcode;
            req.lo = i_first_arg;
            req.hi = i_second_arg;
            req.seed = i_seed_value;
            expected_draws.insert(expected_draws.size(), predict_draw(req));
        end
        if (out_fire) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result: value %h error %b", o_value, o_error);
                fail_count++;
            end else begin
                want = expected_draws.pop_front();
                if (o_value !== want.value) begin
                    $error("value mismatch: expected %h, actual %h", want.value, o_value);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $error("error mismatch: expected %b, actual %b", want.err, o_error);
                    fail_count++;
                end
            end
        end
        quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("pcg32_random_with_range_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_request(OP_RAW, '0, '0, '0);
        add_request(OP_RAW, '1, '1, '1);
        add_request(OP_MOD, '0, '0, '0);
        add_request(OP_MOD, '0, 32'hFFFF_FFFF, '0);
        add_request(OP_MOD, '0, 32'd1, '0);
        add_request(OP_MOD, '0, 32'd999, '0);
        add_request(OP_RANGE, '0, 32'hFFFF_FFFF, '0);
        add_request(OP_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        add_request(OP_RANGE, 32'd5, 32'd4, '0);
        add_request(OP_RANGE, 32'hFFFF_FFFF, '0, '0);
        add_request(OP_RANGE, '0, '0, '0);
        add_request(OP_RANGE, 32'd100, 32'd200, '0);
        add_request(OP_EVEN, '0, '0, '0);
        add_request(OP_EVEN, '1, '1, '1);
        add_request(OP_CHANCE, '0, '0, '0);
        add_request(OP_CHANCE, 32'd1, '0, '0);
        add_request(OP_CHANCE, 32'd2, '0, '0);
        add_request(OP_CHANCE, 32'hFFFF_FFFF, '0, '0);
        add_request(OP_RESEED, '0, '0, '0);
        add_request(OP_RAW, '0, '0, '0);
        add_request(OP_RESEED, '0, '0, '1);
        add_request(OP_RAW, '0, '0, '0);
        add_request(OP_RESEED, '0, '0, 64'd0 - PCG_INC);
        add_request(OP_RAW, '0, '0, '0);
        add_request(OP_UNUSED_LO, '1, '1, '1);
        add_request(OP_UNUSED_HI, '1, '1, '1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 0) begin
                hold_kick = ~hold_kick;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                add_random_request();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("pcg32_random_with_range_tb passed");
        end else begin
            $display("pcg32_random_with_range_tb failed");
        end
        $finish;
    end

endmodule
